@@ rtl/address_region_translation_table_assert.svh @@
// assertion macros for the translation table checker
`ifndef ADDRESS_REGION_TRANSLATION_TABLE_ASSERT_SVH
`define ADDRESS_REGION_TRANSLATION_TABLE_ASSERT_SVH

// same-cycle implication, sampled on clk, off while rst is high
`define ARTT_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("artt assertion failed");

// next-cycle implication, sampled on clk, off while rst is high
`define ARTT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("artt assertion failed");

`endif

@@ rtl/artt_pkg.sv @@
// shared types and constants for the address region translation table
package artt_pkg;

  localparam int ENTRIES = 16;
  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

  typedef enum logic [1:0] {
    FUNC_LOOKUP = 2'd0,
    FUNC_ADD    = 2'd1,
    FUNC_REMOVE = 2'd2,
    FUNC_CLEAR  = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_LAST,
    ST_CALC,
    ST_RESULT
  } state_t;

  typedef struct packed {
    func_t       func;
    logic [63:0] address;
    logic [63:0] target_addr;
    logic [63:0] region_size;
    logic [7:0]  mem_type;
  } req_t;

  typedef struct packed {
    logic        hit;
    logic [63:0] translated_addr;
    logic [7:0]  type_out;
    logic        status;
  } rsp_t;

  typedef struct packed {
    logic [63:0] base;
    logic [63:0] target;
    logic [63:0] length;
    logic [7:0]  mem_type;
  } entry_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    entry_t           data;
  } ram_wr_t;

endpackage

@@ rtl/artt_entry_ram.sv @@
// region entry memory, one write port, one registered read port
module artt_entry_ram (
  input  logic                          clk,
  input  artt_pkg::ram_wr_t             wr,
  input  logic [artt_pkg::IDX_W-1:0]    raddr,
  output artt_pkg::entry_t              rdata
);

  artt_pkg::entry_t mem [artt_pkg::ENTRIES];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/artt_engine.sv @@
// scan sequencer: valid bits, entry compare and result build
module artt_engine (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  artt_pkg::req_t                item,
  output logic                          busy,
  output artt_pkg::ram_wr_t             wr,
  output logic [artt_pkg::IDX_W-1:0]    raddr,
  input  artt_pkg::entry_t              rdata,
  output logic                          res_valid,
  output artt_pkg::rsp_t                res,
  input  logic                          res_take
);

  artt_pkg::state_t state, state_next;

  logic [artt_pkg::ENTRIES-1:0] valid;
  logic [artt_pkg::IDX_W-1:0]   rd_idx;
  logic [artt_pkg::IDX_W-1:0]   cmp_idx;
  logic                         cmp_pend;
  logic                         found;
  logic                         match;
  logic                         have_free;
  logic                         full;

  artt_pkg::func_t              op;
  logic [63:0]                  key;
  logic [63:0]                  new_target;
  logic [63:0]                  new_length;
  logic [7:0]                   new_type;
  artt_pkg::entry_t             best;
  logic [63:0]                  offset;
  logic [artt_pkg::IDX_W-1:0]   match_idx;
  logic [artt_pkg::IDX_W-1:0]   free_idx;

  logic ent_valid;
  logic base_eq;
  logic lk_better;
  logic hit_w;

  assign ent_valid = valid[cmp_idx];
  assign base_eq   = (rdata.base == key);
  assign lk_better = ent_valid && (rdata.base <= key) && (!found || (rdata.base > best.base));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= artt_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    busy       = (state != artt_pkg::ST_IDLE);
    res_valid  = 1'b0;
    unique case (state)
      artt_pkg::ST_IDLE: begin
        if (start) begin
          state_next = (item.func == artt_pkg::FUNC_CLEAR) ? artt_pkg::ST_RESULT
                                                          : artt_pkg::ST_SCAN;
        end
      end
      artt_pkg::ST_SCAN: begin
        if (rd_idx == artt_pkg::LAST_IDX) begin
          state_next = artt_pkg::ST_LAST;
        end
      end
      artt_pkg::ST_LAST: begin
        state_next = artt_pkg::ST_CALC;
      end
      artt_pkg::ST_CALC: begin
        state_next = artt_pkg::ST_RESULT;
      end
      artt_pkg::ST_RESULT: begin
        res_valid = 1'b1;
        if (res_take) begin
          state_next = artt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = artt_pkg::ST_IDLE;
      end
    endcase
  end

  // memory ports
  assign raddr         = rd_idx;
  assign wr.en         = (state == artt_pkg::ST_CALC) && (op == artt_pkg::FUNC_ADD)
                         && (match || have_free);
  assign wr.addr       = match ? match_idx : free_idx;
  assign wr.data.base     = key;
  assign wr.data.target   = new_target;
  assign wr.data.length   = new_length;
  assign wr.data.mem_type = new_type;

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      valid     <= '0;
      rd_idx    <= '0;
      cmp_pend  <= 1'b0;
      found     <= 1'b0;
      match     <= 1'b0;
      have_free <= 1'b0;
      full      <= 1'b0;
    end else begin
      cmp_pend <= (state == artt_pkg::ST_SCAN);
      if (start) begin
        rd_idx    <= '0;
        found     <= 1'b0;
        match     <= 1'b0;
        have_free <= 1'b0;
        full      <= 1'b0;
        if (item.func == artt_pkg::FUNC_CLEAR) begin
          valid <= '0;
        end
      end else if (state == artt_pkg::ST_SCAN) begin
        rd_idx <= rd_idx + 1'b1;
      end
      if (cmp_pend) begin
        unique case (op)
          artt_pkg::FUNC_LOOKUP: begin
            if (lk_better) begin
              found <= 1'b1;
            end
          end
          artt_pkg::FUNC_ADD: begin
            if (ent_valid && base_eq) begin
              match <= 1'b1;
            end
            if (!ent_valid) begin
              have_free <= 1'b1;
            end
          end
          artt_pkg::FUNC_REMOVE: begin
            if (ent_valid && base_eq) begin
              valid[cmp_idx] <= 1'b0;
            end
          end
          artt_pkg::FUNC_CLEAR: begin
          end
          default: begin
          end
        endcase
      end
      if (state == artt_pkg::ST_CALC) begin
        full <= (op == artt_pkg::FUNC_ADD) && !(match || have_free);
        if (wr.en) begin
          valid[wr.addr] <= 1'b1;
        end
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    cmp_idx <= rd_idx;
    if (start) begin
      op         <= item.func;
      key        <= item.address;
      new_target <= item.target_addr;
      new_length <= item.region_size;
      new_type   <= item.mem_type;
    end
    if (cmp_pend) begin
      if ((op == artt_pkg::FUNC_LOOKUP) && lk_better) begin
        best <= rdata;
      end
      if (ent_valid && base_eq && !match) begin
        match_idx <= cmp_idx;
      end
      if (!ent_valid && !have_free) begin
        free_idx <= cmp_idx;
      end
    end
    if (state == artt_pkg::ST_CALC) begin
      offset <= key - best.base;
    end
  end

  assign hit_w = (op == artt_pkg::FUNC_LOOKUP) && found && (offset < best.length);

  assign res.hit             = hit_w;
  assign res.translated_addr = hit_w ? (best.target + offset) : 64'd0;
  assign res.type_out        = hit_w ? best.mem_type : 8'd0;
  assign res.status          = full;

endmodule

@@ rtl/address_region_translation_table.sv @@
// top level of the region based address translation table
//
//  channel | valid     | stall     | word
//  --------+-----------+-----------+--------------------------------------------
//  request | req_valid | req_stall | req: func, address, target_addr, size, type
//  result  | rsp_valid | rsp_stall | rsp: hit, translated_addr, type_out, status
//
// one request word at a time; lookup, add and remove scan every entry through the
// single read port, pass ST_LAST and ST_CALC and load the result register;
// the next word is taken once that result moves out (clear skips the scan)
// reset empties the table at once through per-entry valid bits, no sweep
// a result waits in the output register while the next word is taken in;
// req_stall stays high while a scan is running or a finished result has nowhere to go
module address_region_translation_table (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_stall,
  input  artt_pkg::req_t   req,
  output logic             rsp_valid,
  input  logic             rsp_stall,
  output artt_pkg::rsp_t   rsp
);

  logic                         busy;
  logic                         start;
  artt_pkg::ram_wr_t            wr;
  logic [artt_pkg::IDX_W-1:0]   raddr;
  artt_pkg::entry_t             rdata;
  logic                         res_valid;
  artt_pkg::rsp_t               res;
  logic                         res_take;

  // new word only while the sequencer sits idle
  assign req_stall = busy;
  assign start     = req_valid && !req_stall;

  // output register is free when empty or being drained this cycle
  assign res_take = !rsp_valid || !rsp_stall;

  artt_entry_ram u_ram (
    .clk   (clk),
    .wr    (wr),
    .raddr (raddr),
    .rdata (rdata)
  );

  artt_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .item      (req),
    .busy      (busy),
    .wr        (wr),
    .raddr     (raddr),
    .rdata     (rdata),
    .res_valid (res_valid),
    .res       (res),
    .res_take  (res_take)
  );

  // result output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (res_valid && res_take) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_take) begin
      rsp <= res;
    end
  end

endmodule

@@ rtl/artt_checker.sv @@
// port level checks for the translation table, bound to the top level
`include "address_region_translation_table_assert.svh"

module artt_checker (
  input logic            clk,
  input logic            rst,
  input logic            req_valid,
  input logic            req_stall,
  input logic            rsp_valid,
  input logic            rsp_stall,
  input artt_pkg::rsp_t  rsp
);

  // a hit only comes from a lookup, full only from an add
  `ARTT_ASSERT_NOW(a_hit_no_full, rsp_valid && rsp.hit, !rsp.status)

  // a miss carries zero address and type
  `ARTT_ASSERT_NOW(a_miss_zero, rsp_valid && !rsp.hit, rsp.translated_addr == '0 && rsp.type_out == '0)

  // an accepted word keeps the block busy on the next cycle
  `ARTT_ASSERT_NEXT(a_busy_after_accept, req_valid && !req_stall, req_stall)

  // a stalled result word holds
  `ARTT_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp))

endmodule

bind address_region_translation_table artt_checker u_artt_checker (.*);

@@ test/tb.sv @@
// self-checking testbench for the address region translation table
module tb;

  // shorthands for the stimulus table and the key pool
  localparam logic [63:0] ALL_ONES = 64'hffff_ffff_ffff_ffff;
  localparam int POOL = artt_pkg::ENTRIES + 8;
  localparam int HOLD_CYCLES = 400;
  localparam int PHASE_WORDS = 160;

  logic clk;
  logic rst;
  logic req_valid;
  logic req_stall;
  artt_pkg::req_t req;
  logic rsp_valid;
  logic rsp_stall;
  artt_pkg::rsp_t rsp;

  address_region_translation_table dut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp(rsp)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow copy of the region table, updated on every accepted request word
  logic        shadow_valid [artt_pkg::ENTRIES];
  logic [63:0] shadow_base [artt_pkg::ENTRIES];
  logic [63:0] shadow_target [artt_pkg::ENTRIES];
  logic [63:0] shadow_length [artt_pkg::ENTRIES];
  logic [7:0]  shadow_type [artt_pkg::ENTRIES];

  // results owed by the block, oldest first
  artt_pkg::rsp_t pending_rsp [$];

  // one row of the directed table: the request word and, where it is obvious,
  // the result typed in by hand
  typedef struct {
    artt_pkg::req_t word;
    bit             typed;
    artt_pkg::rsp_t want;
  } stim_row_t;
  stim_row_t directed_rows [$];

  // base keys shared by adds, removes and lookups so that they meet each other
  logic [63:0] key_pool [POOL];

  int send_idle_pct = 0;
  int stall_pct = 0;
  bit pressure_on = 1'b0;

  int mismatches = 0;
  int words_sent = 0;
  int results_seen = 0;
  int hits_seen = 0;
  int full_seen = 0;

  // apply one request word to the shadow table and return the result it owes
  function automatic artt_pkg::rsp_t region_table_step(artt_pkg::req_t w);
    artt_pkg::rsp_t r;
    int best;
    int match;
    int free_slot;
    int slot;
    logic [63:0] offset;
    r = '0;
    best = -1;
    match = -1;
    free_slot = -1;
    case (w.func)
      artt_pkg::FUNC_LOOKUP: begin
        // greatest valid base not above the address; only that region counts
        for (int i = 0; i < artt_pkg::ENTRIES; i++) begin
          if (shadow_valid[i] && shadow_base[i] <= w.address) begin
            if (best < 0 || shadow_base[i] > shadow_base[best]) best = i;
          end
        end
        if (best >= 0) begin
          offset = w.address - shadow_base[best];
          if (offset < shadow_length[best]) begin
            r.hit = 1'b1;
            r.translated_addr = shadow_target[best] + offset;
            r.type_out = shadow_type[best];
            hits_seen++;
          end
        end
      end
      artt_pkg::FUNC_ADD: begin
        for (int i = 0; i < artt_pkg::ENTRIES; i++) begin
          if (match < 0 && shadow_valid[i] && shadow_base[i] == w.address) match = i;
          if (free_slot < 0 && !shadow_valid[i]) free_slot = i;
        end
        // same base overwrites in place, else lowest free slot, else full
        slot = (match >= 0) ? match : free_slot;
        if (slot < 0) begin
          r.status = 1'b1;
          full_seen++;
        end else begin
          shadow_valid[slot] = 1'b1;
          shadow_base[slot] = w.address;
          shadow_target[slot] = w.target_addr;
          shadow_length[slot] = w.region_size;
          shadow_type[slot] = w.mem_type;
        end
      end
      artt_pkg::FUNC_REMOVE: begin
        for (int i = 0; i < artt_pkg::ENTRIES; i++) begin
          if (shadow_valid[i] && shadow_base[i] == w.address) shadow_valid[i] = 1'b0;
        end
      end
      default: begin
        for (int i = 0; i < artt_pkg::ENTRIES; i++) shadow_valid[i] = 1'b0;
      end
    endcase
    return r;
  endfunction

  task automatic flag_mismatch(string what, logic [63:0] got, logic [63:0] want);
    mismatches++;
    $display("mismatch at %0t: %s got %h want %h", $time, what, got, want);
  endtask

  task automatic add_row(artt_pkg::func_t f, logic [63:0] a, logic [63:0] t,
                         logic [63:0] s, logic [7:0] ty, bit typed, logic h,
                         logic [63:0] x, logic [7:0] tyo, logic st);
    stim_row_t row;
    row.word.func = f;
    row.word.address = a;
    row.word.target_addr = t;
    row.word.region_size = s;
    row.word.mem_type = ty;
    row.typed = typed;
    row.want.hit = h;
    row.want.translated_addr = x;
    row.want.type_out = tyo;
    row.want.status = st;
    directed_rows = {directed_rows, row};
  endtask

  // offer one request word, with random idle cycles ahead of it, and record
  // its expected result once the block takes it
  task automatic push_word(input artt_pkg::req_t w, input bit typed,
                           input artt_pkg::rsp_t want);
    artt_pkg::rsp_t predicted;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= w;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    predicted = region_table_step(w);
    pending_rsp = {pending_rsp, (typed ? want : predicted)};
    words_sent++;
  endtask

  function automatic artt_pkg::req_t random_word();
    artt_pkg::req_t w;
    int pick;
    pick = $urandom_range(0, 99);
    w.address = {$urandom, $urandom};
    w.target_addr = {$urandom, $urandom};
    w.mem_type = 8'($urandom);
    // sizes: zero, tiny, full range, everything, and the usual few pages
    case ($urandom_range(0, 4))
      0: w.region_size = '0;
      1: w.region_size = 64'($urandom_range(1, 16));
      2: w.region_size = {$urandom, $urandom};
      3: w.region_size = ALL_ONES;
      default: w.region_size = 64'($urandom_range(1, 'h2000));
    endcase
    if (pick < 35) begin
      w.func = artt_pkg::FUNC_ADD;
      if ($urandom_range(0, 9) != 0) w.address = key_pool[$urandom_range(0, POOL - 1)];
    end else if (pick < 42) begin
      w.func = artt_pkg::FUNC_REMOVE;
      if ($urandom_range(0, 9) != 0) w.address = key_pool[$urandom_range(0, POOL - 1)];
    end else if (pick < 43) begin
      w.func = artt_pkg::FUNC_CLEAR;
    end else begin
      // lookups land inside, just below and just past known bases, or anywhere
      w.func = artt_pkg::FUNC_LOOKUP;
      case ($urandom_range(0, 3))
        0: w.address = key_pool[$urandom_range(0, POOL - 1)] + 64'($urandom_range(0, 'h2400));
        1: w.address = key_pool[$urandom_range(0, POOL - 1)] - 64'd1;
        2: w.address = key_pool[$urandom_range(0, POOL - 1)] + 64'($urandom_range(0, 15));
        default: ;
      endcase
    end
    return w;
  endfunction

  // more adds with distinct keys than there are slots, so the table runs full
  task automatic fill_burst();
    artt_pkg::req_t w;
    for (int i = 0; i < artt_pkg::ENTRIES + 2; i++) begin
      w = random_word();
      w.func = artt_pkg::FUNC_ADD;
      w.address = key_pool[i];
      push_word(w, 1'b0, '0);
    end
  endtask

  task automatic run_phase(int idle, int stall, int count);
    send_idle_pct = idle;
    stall_pct = stall;
    fill_burst();
    repeat (count) push_word(random_word(), 1'b0, '0);
  endtask

  // result side: random stall, plus one long hold-off while the sender keeps
  // offering, so the block backs up and stalls its request side
  initial begin : receiver
    bit hold_done;
    hold_done = 1'b0;
    forever begin
      if (pressure_on && !hold_done) begin
        hold_done = 1'b1;
        rsp_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        rsp_stall <= ($urandom_range(0, 99) < stall_pct);
      end
      @(posedge clk);
    end
  end

  // result checker: every accepted result against the oldest expectation
  always @(posedge clk) begin : check_rsp
    artt_pkg::rsp_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      results_seen++;
      if (pending_rsp.size() == 0) begin
        flag_mismatch("result word with nothing pending", rsp.translated_addr, 64'd0);
      end else begin
        want = pending_rsp.pop_front();
        if (rsp.hit !== want.hit) flag_mismatch("hit", 64'(rsp.hit), 64'(want.hit));
        if (rsp.translated_addr !== want.translated_addr) begin
          flag_mismatch("translated_addr", rsp.translated_addr, want.translated_addr);
        end
        if (rsp.type_out !== want.type_out) begin
          flag_mismatch("type_out", 64'(rsp.type_out), 64'(want.type_out));
        end
        if (rsp.status !== want.status) begin
          flag_mismatch("status", 64'(rsp.status), 64'(want.status));
        end
      end
    end
  end

  // generous bound: several times the slowest run, long hold-off included
  initial begin
    #3_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin : main
    rst <= 1'b1;
    req_valid <= 1'b0;
    req <= '0;
    for (int i = 0; i < artt_pkg::ENTRIES; i++) shadow_valid[i] = 1'b0;
    // keys near the bottom, near the top, and anywhere
    for (int i = 0; i < POOL; i++) begin
      case (i % 3)
        0: key_pool[i] = (i == 0) ? 64'h0 : {$urandom, $urandom};
        1: key_pool[i] = 64'(i) * 64'h4000;
        default: key_pool[i] = ALL_ONES - 64'(i) * 64'h3000;
      endcase
    end

    // directed table; rows with chk 0 are left to the shadow table
    //      func         address                 target                  size
    //      type   chk hit xlat                  type   st
    add_row(artt_pkg::FUNC_LOOKUP, 64'h0, 64'h0, 64'h0,
            8'h00, 1'b1, 1'b0, 64'h0, 8'h00, 1'b0);          // empty table, bottom
    add_row(artt_pkg::FUNC_LOOKUP, ALL_ONES, ALL_ONES, ALL_ONES,
            8'hff, 1'b1, 1'b0, 64'h0, 8'h00, 1'b0);          // empty table, top
    add_row(artt_pkg::FUNC_REMOVE, 64'h5, 64'h0, 64'h0,
            8'h00, 1'b1, 1'b0, 64'h0, 8'h00, 1'b0);          // remove of an absent base
    add_row(artt_pkg::FUNC_ADD, 64'h0, ALL_ONES, 64'h10,
            8'hff, 1'b1, 1'b0, 64'h0, 8'h00, 1'b0);
    add_row(artt_pkg::FUNC_LOOKUP, 64'hf, 64'h0, 64'h0,
            8'h00, 1'b1, 1'b1, 64'he, 8'hff, 1'b0);          // target plus offset wraps
    add_row(artt_pkg::FUNC_LOOKUP, 64'h10, 64'h0, 64'h0,
            8'h00, 1'b1, 1'b0, 64'h0, 8'h00, 1'b0);          // one past the end
    add_row(artt_pkg::FUNC_ADD, 64'h100, 64'h5000, 64'h0,
            8'h5a, 1'b1, 1'b0, 64'h0, 8'h00, 1'b0);          // zero length region
    add_row(artt_pkg::FUNC_LOOKUP, 64'h100, 64'h0, 64'h0,
            8'h00, 1'b1, 1'b0, 64'h0, 8'h00, 1'b0);          // zero length never hits
    add_row(artt_pkg::FUNC_ADD, ALL_ONES, 64'h0, ALL_ONES,
            8'h01, 1'b1, 1'b0, 64'h0, 8'h00, 1'b0);          // base and size at the top
    add_row(artt_pkg::FUNC_LOOKUP, ALL_ONES, 64'h0, 64'h0,
            8'h00, 1'b1, 1'b1, 64'h0, 8'h01, 1'b0);
    add_row(artt_pkg::FUNC_ADD, 64'h0, 64'h1000, 64'h20,
            8'h33, 1'b1, 1'b0, 64'h0, 8'h00, 1'b0);          // same base overwrites
    add_row(artt_pkg::FUNC_LOOKUP, 64'h1f, 64'h0, 64'h0,
            8'h00, 1'b1, 1'b1, 64'h101f, 8'h33, 1'b0);
    add_row(artt_pkg::FUNC_LOOKUP, 64'h105, 64'h0, 64'h0,
            8'h00, 1'b1, 1'b0, 64'h0, 8'h00, 1'b0);          // nearest base is empty
    add_row(artt_pkg::FUNC_LOOKUP, 64'h8000_0000_0000_0000, 64'h0, 64'h0,
            8'h00, 1'b0, 1'b0, 64'h0, 8'h00, 1'b0);
    add_row(artt_pkg::FUNC_ADD, 64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210,
            64'h0000_ffff_0000_ffff,
            8'ha5, 1'b0, 1'b0, 64'h0, 8'h00, 1'b0);
    add_row(artt_pkg::FUNC_LOOKUP, 64'h0123_4567_89ac_0000, 64'h0, 64'h0,
            8'h00, 1'b0, 1'b0, 64'h0, 8'h00, 1'b0);
    add_row(artt_pkg::FUNC_REMOVE, 64'h100, 64'h0, 64'h0,
            8'h00, 1'b1, 1'b0, 64'h0, 8'h00, 1'b0);
    add_row(artt_pkg::FUNC_LOOKUP, 64'h105, 64'h0, 64'h0,
            8'h00, 1'b1, 1'b0, 64'h0, 8'h00, 1'b0);          // offset beyond base 0 length
    add_row(artt_pkg::FUNC_REMOVE, 64'h100, 64'h0, 64'h0,
            8'h00, 1'b1, 1'b0, 64'h0, 8'h00, 1'b0);          // already gone
    add_row(artt_pkg::FUNC_CLEAR, ALL_ONES, ALL_ONES, ALL_ONES,
            8'hff, 1'b1, 1'b0, 64'h0, 8'h00, 1'b0);          // other fields ignored
    add_row(artt_pkg::FUNC_LOOKUP, ALL_ONES, 64'h0, 64'h0,
            8'h00, 1'b1, 1'b0, 64'h0, 8'h00, 1'b0);
    add_row(artt_pkg::FUNC_LOOKUP, 64'h1f, 64'h0, 64'h0,
            8'h00, 1'b1, 1'b0, 64'h0, 8'h00, 1'b0);

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      push_word(directed_rows[i].word, directed_rows[i].typed, directed_rows[i].want);
    end

    // random phases: free flow with one long hold-off, then idle and stall mixes
    pressure_on = 1'b1;
    run_phase(0, 0, PHASE_WORDS);
    run_phase(50, 0, PHASE_WORDS);
    run_phase(0, 50, PHASE_WORDS);
    run_phase(30, 30, PHASE_WORDS);

    req_valid <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk);
    // catch any stray result word after the last expected one
    repeat (4 * (artt_pkg::ENTRIES + 4)) @(posedge clk);

    $display("covered %0d request words and %0d result words", words_sent, results_seen);
    $display("lookup hits %0d, adds refused on a full table %0d, mismatches %0d",
             hits_seen, full_seen, mismatches);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
